// ===== src/tmg_pkg.sv =====
// Shared types, constants and arithmetic helpers of the torus mesh generator.
`timescale 1ns / 1ps
package tmg_pkg;

  localparam int MAX_RINGS    = 256;
  localparam int MAX_SIDES    = 256;
  localparam int CORDIC_STEPS = 18;

  localparam int COUNT_W   = 9;
  localparam int IDX_W     = 9;
  localparam int RAD_W     = 18;
  localparam int VAL_W     = 21;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int REC_W     = 3;
  localparam int FACE_W    = 17;

  localparam int PHASE_W  = 32;
  localparam int Q_W      = PHASE_W + 1;
  localparam int CW       = 33;
  localparam int FRAC     = 30;
  localparam int OUT_FRAC = 16;
  localparam int TEX_LSB  = PHASE_W - OUT_FRAC - 1;
  localparam int TEX_W    = Q_W - TEX_LSB;
  localparam int ZPROD_W  = 61;

  localparam int DIV_STEP_BITS    = 8;
  localparam int DIV_STAGES       = PHASE_W / DIV_STEP_BITS;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;
  localparam int ANGLE_LAT        = DIV_STAGES + CORDIC_STAGES + 2;
  localparam int BACK_LAT         = ANGLE_LAT + 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam int RP_W = RAD_W + 1 + CW;
  localparam int NP_W = 63;
  localparam int A_W  = 23;
  localparam int PP_W = CW + A_W;

  localparam logic [FRAC:0]         HALF_PI_Q30  = 31'd1686629713;
  localparam logic signed [CW-1:0]  CORDIC_START = 33'sd652032874;
  localparam logic signed [63:0]    SAT_HI       = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
  localparam logic signed [63:0]    SAT_LO       = -(64'sd1 <<< (VAL_W - 1));

  localparam logic [COUNT_W-1:0] RING_COUNT_RST   = 9'd10;
  localparam logic [COUNT_W-1:0] SIDE_COUNT_RST   = 9'd10;
  localparam logic [RAD_W-1:0]   INNER_RADIUS_RST = 18'd16384;
  localparam logic [RAD_W-1:0]   OUTER_RADIUS_RST = 18'd49152;

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_FACE   = 1'b1
  } cmd_t;

  typedef enum logic [REC_W-1:0] {
    REC_POSITION = 3'd0,
    REC_TEXCOORD = 3'd1,
    REC_TANGENT  = 3'd2,
    REC_NORMAL   = 3'd3,
    REC_FACE     = 3'd4
  } rec_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_COUNT     = 3'd0,
    CFG_SIDE_COUNT     = 3'd1,
    CFG_INNER_RADIUS   = 3'd2,
    CFG_OUTER_RADIUS   = 3'd3,
    CFG_CLOSED_MODE    = 3'd4,
    CFG_EMIT_NORMALS   = 3'd5,
    CFG_EMIT_TEXCOORDS = 3'd6,
    CFG_EMIT_TANGENTS  = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [COUNT_W-1:0] ring_count;
    logic [COUNT_W-1:0] side_count;
    logic [RAD_W-1:0]   inner_radius;
    logic [RAD_W-1:0]   outer_radius;
    logic               closed_mode;
    logic               emit_normals;
    logic               emit_texcoords;
    logic               emit_tangents;
  } cfg_t;

  typedef struct packed {
    logic              is_face;
    logic [IDX_W-1:0]  ring_index;
    logic [IDX_W-1:0]  side_index;
    logic [FACE_W-1:0] face_a;
    logic [FACE_W-1:0] face_b;
    logic [FACE_W-1:0] face_c;
    logic [FACE_W-1:0] face_f;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] rem;
    logic [Q_W-1:0]     q;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] v, int max_count);
    logic [COUNT_W-1:0] r;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > COUNT_W'(max_count)) begin
      r = COUNT_W'(max_count);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic div_t div_step(div_t d, logic [COUNT_W-1:0] cnt);
    logic [COUNT_W:0] t;
    div_t r;
    r = d;
    for (int b = 0; b < DIV_STEP_BITS; b++) begin
      t = {r.rem, 1'b0};
      if (t >= {1'b0, cnt}) begin
        r.rem = COUNT_W'(t - {1'b0, cnt});
        r.q   = {r.q[Q_W-2:0], 1'b1};
      end else begin
        r.rem = COUNT_W'(t);
        r.q   = {r.q[Q_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] atan_q30(int k);
    logic signed [CW-1:0] a;
    unique case (k)
      0:  a = 33'sd843314857;
      1:  a = 33'sd497837829;
      2:  a = 33'sd263043837;
      3:  a = 33'sd133525159;
      4:  a = 33'sd67021687;
      5:  a = 33'sd33543516;
      6:  a = 33'sd16775851;
      7:  a = 33'sd8388437;
      8:  a = 33'sd4194283;
      9:  a = 33'sd2097149;
      10: a = 33'sd1048576;
      11: a = 33'sd524288;
      12: a = 33'sd262144;
      13: a = 33'sd131072;
      14: a = 33'sd65536;
      15: a = 33'sd32768;
      16: a = 33'sd16384;
      17: a = 33'sd8192;
      18: a = 33'sd4096;
      19: a = 33'sd2048;
      20: a = 33'sd1024;
      21: a = 33'sd512;
      22: a = 33'sd256;
      23: a = 33'sd128;
      24: a = 33'sd64;
      25: a = 33'sd32;
      26: a = 33'sd16;
      27: a = 33'sd8;
      28: a = 33'sd4;
      29: a = 33'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic cordic_t cordic_stage(cordic_t c, int first);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    cordic_t r;
    int k;
    r = c;
    for (int s = 0; s < CORDIC_PER_STAGE; s++) begin
      k = first + s;
      if (k < CORDIC_STEPS) begin
        dx = $signed(r.y) >>> k;
        dy = $signed(r.x) >>> k;
        if (!r.z[CW-1]) begin
          r.x = $signed(r.x) - dx;
          r.y = $signed(r.y) + dy;
          r.z = $signed(r.z) - atan_q30(k);
        end else begin
          r.x = $signed(r.x) + dx;
          r.y = $signed(r.y) - dy;
          r.z = $signed(r.z) + atan_q30(k);
        end
      end
    end
    return r;
  endfunction

  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/torus_mesh_generator.sv =====
// Top level of the torus mesh generator: configuration registers, front end, queue, back end.
//
//  Channel   Direction  Transfer condition      Payload
//  command   in         start & !busy           command, ring_index, side_index
//  config    in         cfg_write               cfg_index, cfg_data
//  record    out        valid (one cycle)       record_type, value_a/b/c, last
//
// A vertex produces one record per cycle (1 to 4 records), a face two records;
// the record emitter sets the rate. Out-of-grid commands are dropped in the front end.
// The delay from the transfer to the first record is set by the division and CORDIC
// pipeline depth. busy rises only when the four-entry queue is full.
// Reset is synchronous and clears the queue, pipeline valid bits and registers to defaults.
`timescale 1ns / 1ps
module torus_mesh_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [tmg_pkg::IDX_W-1:0]         ring_index,
  input  logic [tmg_pkg::IDX_W-1:0]         side_index,
  input  logic                              cfg_write,
  input  logic [tmg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmg_pkg::CFG_W-1:0]         cfg_data,
  output logic                              valid,
  output logic [tmg_pkg::REC_W-1:0]         record_type,
  output logic signed [tmg_pkg::VAL_W-1:0]  value_a,
  output logic signed [tmg_pkg::VAL_W-1:0]  value_b,
  output logic signed [tmg_pkg::VAL_W-1:0]  value_c,
  output logic                              last
);
  import tmg_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  head_valid;
  logic  full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_count     <= RING_COUNT_RST;
      cfg.side_count     <= SIDE_COUNT_RST;
      cfg.inner_radius   <= INNER_RADIUS_RST;
      cfg.outer_radius   <= OUTER_RADIUS_RST;
      cfg.closed_mode    <= 1'b0;
      cfg.emit_normals   <= 1'b1;
      cfg.emit_texcoords <= 1'b1;
      cfg.emit_tangents  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RING_COUNT:     cfg.ring_count     <= cfg_data[COUNT_W-1:0];
        CFG_SIDE_COUNT:     cfg.side_count     <= cfg_data[COUNT_W-1:0];
        CFG_INNER_RADIUS:   cfg.inner_radius   <= cfg_data[RAD_W-1:0];
        CFG_OUTER_RADIUS:   cfg.outer_radius   <= cfg_data[RAD_W-1:0];
        CFG_CLOSED_MODE:    cfg.closed_mode    <= cfg_data[0];
        CFG_EMIT_NORMALS:   cfg.emit_normals   <= cfg_data[0];
        CFG_EMIT_TEXCOORDS: cfg.emit_texcoords <= cfg_data[0];
        CFG_EMIT_TANGENTS:  cfg.emit_tangents  <= cfg_data[0];
      endcase
    end
  end

  assign busy = full;

  tmg_front u_front (
    .start      (start),
    .busy       (busy),
    .command    (command),
    .ring_index (ring_index),
    .side_index (side_index),
    .cfg        (cfg),
    .push       (push),
    .item       (push_item)
  );

  tmg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  tmg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .valid       (valid),
    .record_type (record_type),
    .value_a     (value_a),
    .value_b     (value_b),
    .value_c     (value_c),
    .last        (last)
  );

endmodule

// ===== src/tmg_front.sv =====
// Command classification and face index generation ahead of the queue.
`timescale 1ns / 1ps
module tmg_front (
  input  logic                          start,
  input  logic                          busy,
  input  logic                          command,
  input  logic [tmg_pkg::IDX_W-1:0]     ring_index,
  input  logic [tmg_pkg::IDX_W-1:0]     side_index,
  input  tmg_pkg::cfg_t                 cfg,
  output logic                          push,
  output tmg_pkg::item_t                item
);
  import tmg_pkg::*;

  logic [COUNT_W-1:0] rings;
  logic [COUNT_W-1:0] sides;
  logic               i_wrap;
  logic               j_wrap;
  logic               keep;
  logic [COUNT_W:0]   row_w;
  logic [19:0]        base;
  logic [19:0]        row1;
  logic [19:0]        col1;

  assign rings = clamp_count(cfg.ring_count, MAX_RINGS);
  assign sides = clamp_count(cfg.side_count, MAX_SIDES);

  always_comb begin
    i_wrap = cfg.closed_mode && ({1'b0, ring_index} + 10'd1 == {1'b0, rings});
    j_wrap = cfg.closed_mode && ({1'b0, side_index} + 10'd1 == {1'b0, sides});
    row_w  = cfg.closed_mode ? {1'b0, sides} : {1'b0, sides} + 10'd1;
    base   = 20'(ring_index) * 20'(row_w);
    row1   = i_wrap ? '0 : base + 20'(row_w);
    col1   = j_wrap ? '0 : 20'(side_index) + 20'd1;
    if (cmd_t'(command) == CMD_FACE) begin
      keep = (ring_index < rings) && (side_index < sides);
    end else begin
      keep = (ring_index <= rings) && (side_index <= sides) &&
             !(cfg.closed_mode && ((ring_index == rings) || (side_index == sides)));
    end
  end

  always_comb begin
    item.is_face    = (cmd_t'(command) == CMD_FACE);
    item.ring_index = ring_index;
    item.side_index = side_index;
    item.face_a     = FACE_W'(20'd1 + base + 20'(side_index));
    item.face_b     = FACE_W'(20'd1 + row1 + 20'(side_index));
    item.face_c     = FACE_W'(20'd1 + base + col1);
    item.face_f     = FACE_W'(20'd1 + row1 + col1);
  end

  assign push = start && !busy && keep;

endmodule

// ===== src/tmg_fifo.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module tmg_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmg_pkg::item_t push_item,
  input  logic           pop,
  output tmg_pkg::item_t head,
  output logic           head_valid,
  output logic           full
);
  import tmg_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign do_pop     = pop && (count != '0);
  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/tmg_angle.sv =====
// Pipelined angle unit: turn fraction by long division, then CORDIC sine and cosine.
`timescale 1ns / 1ps
module tmg_angle (
  input  logic                              clk,
  input  logic                              advance,
  input  logic [tmg_pkg::IDX_W-1:0]         idx,
  input  logic [tmg_pkg::COUNT_W-1:0]       count,
  output logic signed [tmg_pkg::CW-1:0]     cos_v,
  output logic signed [tmg_pkg::CW-1:0]     sin_v,
  output logic [tmg_pkg::TEX_W-1:0]         tex
);
  import tmg_pkg::*;

  div_t               div_init;
  div_t               div_r [DIV_STAGES];
  logic [PHASE_W-1:0] phase;
  logic [ZPROD_W-1:0] zprod;
  logic [TEX_W:0]     tex_sum;
  logic [CW-1:0]      z0;
  logic [1:0]         quad0;
  logic [TEX_W-1:0]   tex0;
  cordic_t            cord [CORDIC_STAGES];
  logic [1:0]         quad_line [CORDIC_STAGES];
  logic [TEX_W-1:0]   tex_line [CORDIC_STAGES];
  cordic_t            cord_last;

  always_comb begin
    div_init.q   = Q_W'(idx >= count);
    div_init.rem = (idx >= count) ? COUNT_W'(idx - count) : COUNT_W'(idx);
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (advance) begin
          div_r[s] <= div_step(div_init, count);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (advance) begin
          div_r[s] <= div_step(div_r[s-1], count);
        end
      end
    end
  end

  always_comb begin
    phase   = div_r[DIV_STAGES-1].q[PHASE_W-1:0];
    zprod   = ZPROD_W'(phase[FRAC-1:0]) * ZPROD_W'(HALF_PI_Q30);
    tex_sum = {1'b0, div_r[DIV_STAGES-1].q[Q_W-1:TEX_LSB]} + (TEX_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      z0    <= CW'(zprod[ZPROD_W-1:FRAC]);
      quad0 <= phase[PHASE_W-1:PHASE_W-2];
      tex0  <= tex_sum[TEX_W:1];
    end
  end

  for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
    if (c == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (advance) begin
          cord[c]      <= cordic_stage('{x: CORDIC_START, y: '0, z: z0}, 0);
          quad_line[c] <= quad0;
          tex_line[c]  <= tex0;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (advance) begin
          cord[c]      <= cordic_stage(cord[c-1], c * CORDIC_PER_STAGE);
          quad_line[c] <= quad_line[c-1];
          tex_line[c]  <= tex_line[c-1];
        end
      end
    end
  end

  assign cord_last = cord[CORDIC_STAGES-1];

  always_ff @(posedge clk) begin
    if (advance) begin
      tex <= tex_line[CORDIC_STAGES-1];
      unique case (quad_line[CORDIC_STAGES-1])
        2'd0: begin
          cos_v <= cord_last.x;
          sin_v <= cord_last.y;
        end
        2'd1: begin
          cos_v <= -$signed(cord_last.y);
          sin_v <= cord_last.x;
        end
        2'd2: begin
          cos_v <= -$signed(cord_last.x);
          sin_v <= -$signed(cord_last.y);
        end
        default: begin
          cos_v <= cord_last.y;
          sin_v <= -$signed(cord_last.x);
        end
      endcase
    end
  end

endmodule

// ===== src/tmg_back.sv =====
// Back end: angle units, vertex arithmetic and the record emitter.
`timescale 1ns / 1ps
module tmg_back (
  input  logic                            clk,
  input  logic                            rst,
  input  tmg_pkg::cfg_t                   cfg,
  input  tmg_pkg::item_t                  head,
  input  logic                            head_valid,
  output logic                            pop,
  output logic                            valid,
  output logic [tmg_pkg::REC_W-1:0]       record_type,
  output logic signed [tmg_pkg::VAL_W-1:0] value_a,
  output logic signed [tmg_pkg::VAL_W-1:0] value_b,
  output logic signed [tmg_pkg::VAL_W-1:0] value_c,
  output logic                            last
);
  import tmg_pkg::*;

  logic [COUNT_W-1:0]     rings;
  logic [COUNT_W-1:0]     sides;
  logic                   advance;
  logic signed [CW-1:0]   ct, st, cp, sp;
  logic [TEX_W-1:0]       u_i, u_j;
  logic [BACK_LAT-1:0]    line_valid;
  item_t                  line_item [BACK_LAT];
  logic signed [RAD_W:0]  r_s;

  logic signed [RP_W-1:0] m1_rcp, m1_rsp;
  logic signed [NP_W-1:0] m1_ctcp, m1_stcp;
  logic signed [CW-1:0]   m1_ct, m1_st, m1_sp;
  logic [TEX_W-1:0]       m1_ui, m1_uj;

  logic signed [63:0]     wide;
  logic signed [63:0]     a64;
  logic signed [63:0]     tx0, ty0;
  logic signed [63:0]     tx1, ty1;

  logic signed [A_W-1:0]   m2_a;
  logic signed [CW-1:0]    m2_ct, m2_st;
  logic signed [VAL_W-1:0] m2_pz, m2_nx, m2_ny, m2_nz, m2_tx, m2_ty;
  logic [TEX_W-1:0]        m2_ui, m2_uj;

  logic signed [PP_W-1:0]  m3_px, m3_py;
  logic signed [VAL_W-1:0] m3_pz, m3_nx, m3_ny, m3_nz, m3_tx, m3_ty;
  logic [TEX_W-1:0]        m3_ui, m3_uj;

  item_t                   ld_item;
  logic                    ld_valid;
  logic [NUM_SLOTS-1:0]    ld_mask;
  rec_type_t               ld_type [NUM_SLOTS];
  logic signed [VAL_W-1:0] ld_a [NUM_SLOTS];
  logic signed [VAL_W-1:0] ld_b [NUM_SLOTS];
  logic signed [VAL_W-1:0] ld_c [NUM_SLOTS];

  logic [NUM_SLOTS-1:0]    mask;
  rec_type_t               slot_type [NUM_SLOTS];
  logic signed [VAL_W-1:0] slot_a [NUM_SLOTS];
  logic signed [VAL_W-1:0] slot_b [NUM_SLOTS];
  logic signed [VAL_W-1:0] slot_c [NUM_SLOTS];
  logic [SLOT_W-1:0]       sel;

  assign rings   = clamp_count(cfg.ring_count, MAX_RINGS);
  assign sides   = clamp_count(cfg.side_count, MAX_SIDES);
  assign advance = ((mask & (mask - NUM_SLOTS'(1))) == '0);
  assign pop     = advance && head_valid;
  assign r_s     = $signed({1'b0, cfg.inner_radius});

  tmg_angle u_ring_angle (
    .clk     (clk),
    .advance (advance),
    .idx     (head.ring_index),
    .count   (rings),
    .cos_v   (ct),
    .sin_v   (st),
    .tex     (u_i)
  );

  tmg_angle u_side_angle (
    .clk     (clk),
    .advance (advance),
    .idx     (head.side_index),
    .count   (sides),
    .cos_v   (cp),
    .sin_v   (sp),
    .tex     (u_j)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (advance) begin
      line_valid <= {line_valid[BACK_LAT-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_item[0] <= head;
      for (int s = 1; s < BACK_LAT; s++) begin
        line_item[s] <= line_item[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m1_rcp  <= r_s * cp;
      m1_rsp  <= r_s * sp;
      m1_ctcp <= ct * cp;
      m1_stcp <= st * cp;
      m1_ct   <= ct;
      m1_st   <= st;
      m1_sp   <= sp;
      m1_ui   <= u_i;
      m1_uj   <= u_j;
    end
  end

  always_comb begin
    wide = $signed({16'b0, cfg.outer_radius, 30'b0}) + 64'(m1_rcp);
    a64  = round_shift(64'(m1_rcp), FRAC) + 64'($signed({1'b0, cfg.outer_radius}));
    tx0  = round_shift(-64'(m1_st), FRAC - OUT_FRAC);
    ty0  = round_shift(64'(m1_ct), FRAC - OUT_FRAC);
    priority if (wide == '0) begin
      tx1 = '0;
      ty1 = '0;
    end else if (wide < 0) begin
      tx1 = -tx0;
      ty1 = -ty0;
    end else begin
      tx1 = tx0;
      ty1 = ty0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m2_a  <= a64[A_W-1:0];
      m2_ct <= m1_ct;
      m2_st <= m1_st;
      m2_pz <= sat_val(round_shift(64'(m1_rsp), FRAC));
      m2_nx <= sat_val(round_shift(64'(m1_ctcp), 2 * FRAC - OUT_FRAC));
      m2_ny <= sat_val(round_shift(64'(m1_stcp), 2 * FRAC - OUT_FRAC));
      m2_nz <= sat_val(round_shift(64'(m1_sp), FRAC - OUT_FRAC));
      m2_tx <= sat_val(tx1);
      m2_ty <= sat_val(ty1);
      m2_ui <= m1_ui;
      m2_uj <= m1_uj;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m3_px <= m2_ct * m2_a;
      m3_py <= m2_st * m2_a;
      m3_pz <= m2_pz;
      m3_nx <= m2_nx;
      m3_ny <= m2_ny;
      m3_nz <= m2_nz;
      m3_tx <= m2_tx;
      m3_ty <= m2_ty;
      m3_ui <= m2_ui;
      m3_uj <= m2_uj;
    end
  end

  always_comb begin
    ld_item  = line_item[BACK_LAT-1];
    ld_valid = line_valid[BACK_LAT-1];
    if (ld_item.is_face) begin
      ld_mask    = NUM_SLOTS'(2'b11);
      ld_type[0] = REC_FACE;
      ld_a[0]    = VAL_W'(ld_item.face_a);
      ld_b[0]    = VAL_W'(ld_item.face_b);
      ld_c[0]    = VAL_W'(ld_item.face_c);
      ld_type[1] = REC_FACE;
      ld_a[1]    = VAL_W'(ld_item.face_c);
      ld_b[1]    = VAL_W'(ld_item.face_b);
      ld_c[1]    = VAL_W'(ld_item.face_f);
    end else begin
      ld_mask    = {cfg.emit_normals, cfg.emit_tangents, cfg.emit_texcoords, 1'b1};
      ld_type[0] = REC_POSITION;
      ld_a[0]    = sat_val(round_shift(64'(m3_px), FRAC));
      ld_b[0]    = sat_val(round_shift(64'(m3_py), FRAC));
      ld_c[0]    = m3_pz;
      ld_type[1] = REC_TEXCOORD;
      ld_a[1]    = VAL_W'(m3_ui);
      ld_b[1]    = VAL_W'(m3_uj);
      ld_c[1]    = '0;
    end
    ld_type[2] = REC_TANGENT;
    ld_a[2]    = m3_tx;
    ld_b[2]    = m3_ty;
    ld_c[2]    = '0;
    ld_type[3] = REC_NORMAL;
    ld_a[3]    = m3_nx;
    ld_b[3]    = m3_ny;
    ld_c[3]    = m3_nz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (advance) begin
      mask <= ld_valid ? ld_mask : '0;
    end else begin
      mask <= mask & (mask - NUM_SLOTS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_type[s] <= ld_type[s];
        slot_a[s]    <= ld_a[s];
        slot_b[s]    <= ld_b[s];
        slot_c[s]    <= ld_c[s];
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (mask[s]) begin
        sel = SLOT_W'(s);
      end
    end
  end

  assign valid       = (mask != '0);
  assign last        = valid && advance;
  assign record_type = slot_type[sel];
  assign value_a     = slot_a[sel];
  assign value_b     = slot_b[sel];
  assign value_c     = slot_c[sel];

endmodule

// ===== src/tmg_checker.sv =====
// Port-level assertions for the torus mesh generator and their bind.
`timescale 1ns / 1ps
module tmg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        valid,
  input logic [tmg_pkg::REC_W-1:0]   record_type,
  input logic                        last
);
  import tmg_pkg::*;

  a_last_needs_valid: assert property (@(posedge clk) last |-> valid)
    else $error("last without a valid record");

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("record right after reset");

  a_record_run: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("gap inside a record group");

  a_face_pair: assert property (@(posedge clk) disable iff (rst)
    valid && (record_type == REC_FACE) && !last |=> valid && (record_type == REC_FACE) && last)
    else $error("face records do not come in pairs");

  a_attr_follows: assert property (@(posedge clk) disable iff (rst)
    valid && ((record_type == REC_TEXCOORD) || (record_type == REC_TANGENT) ||
              (record_type == REC_NORMAL)) |-> $past(valid) && !$past(last))
    else $error("vertex attribute without a preceding position");

endmodule

bind torus_mesh_generator tmg_checker u_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the torus mesh generator: random and directed commands, predicted records.
`timescale 1ns / 1ps
module tb;
  import tmg_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    cmd_t            cmd;
    logic [IDX_W-1:0] ri;
    logic [IDX_W-1:0] si;
  } mesh_cmd_t;

  typedef struct {
    rec_type_t               kind;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] c;
    logic                    fin;
  } mesh_rec_t;

  localparam longint ARCTAN_Q30 [18] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192};

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic command;
  logic [IDX_W-1:0] ring_index;
  logic [IDX_W-1:0] side_index;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic valid;
  logic [REC_W-1:0] record_type;
  logic signed [VAL_W-1:0] value_a;
  logic signed [VAL_W-1:0] value_b;
  logic signed [VAL_W-1:0] value_c;
  logic last;

  mesh_cmd_t pending_cmds[$];
  mesh_rec_t expected_recs[$];
  int error_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 1;

  logic [COUNT_W-1:0] m_rings = 10;
  logic [COUNT_W-1:0] m_sides = 10;
  logic [RAD_W-1:0] m_inner = 16384;
  logic [RAD_W-1:0] m_outer = 49152;
  logic m_closed = 0;
  logic m_normals = 1;
  logic m_texcoords = 1;
  logic m_tangents = 1;

  torus_mesh_generator uut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int eff_count(logic [COUNT_W-1:0] v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : int'(v);
  endfunction

  function automatic longint rnd_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [VAL_W-1:0] clip21(longint v);
    if (v > 1048575) return 21'sd1048575;
    if (v < -1048576) return -21'sd1048576;
    return v[VAL_W-1:0];
  endfunction

  function automatic void angle_cos_sin(input int idx, input int cnt,
                                        output longint co, output longint sn);
    longint unsigned num;
    logic [31:0] ph;
    longint x, y, z, dx, dy;
    num = longint'(idx) << 32;
    ph = 32'(num / longint'(cnt));
    z = longint'((longint'(ph[29:0]) * 64'd1686629713) >> 30);
    x = 652032874;
    y = 0;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_Q30[k];
      end else begin
        x += dx; y -= dy; z += ARCTAN_Q30[k];
      end
    end
    case (ph[31:30])
      2'd0: begin co = x;  sn = y;  end
      2'd1: begin co = -y; sn = x;  end
      2'd2: begin co = -x; sn = -y; end
      default: begin co = y; sn = -x; end
    endcase
  endfunction

  function automatic void push_rec(rec_type_t kind, longint a, longint b, longint c, logic fin);
    mesh_rec_t r;
    r.kind = kind;
    r.a = clip21(a);
    r.b = clip21(b);
    r.c = clip21(c);
    r.fin = fin;
    expected_recs.push_back(r);
  endfunction

  function automatic void predict_records(mesh_cmd_t m);
    int rings, sides, i, j, i1, j1, w;
    longint ct, st, cp, sp, r, bigr, wide, amp, tx, ty;
    rings = eff_count(m_rings);
    sides = eff_count(m_sides);
    i = m.ri;
    j = m.si;
    if (m.cmd == CMD_FACE) begin
      if (i >= rings || j >= sides) return;
      if (m_closed) begin
        i1 = (i + 1) % rings;
        j1 = (j + 1) % sides;
        push_rec(REC_FACE, 1 + i * sides + j, 1 + i1 * sides + j, 1 + i * sides + j1, 1'b0);
        push_rec(REC_FACE, 1 + i * sides + j1, 1 + i1 * sides + j, 1 + i1 * sides + j1, 1'b1);
      end else begin
        w = sides + 1;
        push_rec(REC_FACE, 1 + i * w + j, 1 + (i + 1) * w + j, 1 + i * w + j + 1, 1'b0);
        push_rec(REC_FACE, 1 + i * w + j + 1, 1 + (i + 1) * w + j, 1 + (i + 1) * w + j + 1,
                 1'b1);
      end
      return;
    end
    if (i > rings || j > sides) return;
    if (m_closed && (i == rings || j == sides)) return;
    angle_cos_sin(i, rings, ct, st);
    angle_cos_sin(j, sides, cp, sp);
    r = m_inner;
    bigr = m_outer;
    wide = (bigr <<< 30) + r * cp;
    amp = bigr + rnd_shift(r * cp, 30);
    push_rec(REC_POSITION, rnd_shift(ct * amp, 30), rnd_shift(st * amp, 30),
             rnd_shift(r * sp, 30), !(m_texcoords || m_tangents || m_normals));
    if (m_texcoords) begin
      push_rec(REC_TEXCOORD, (longint'(i) * 131072 + rings) / (2 * rings),
               (longint'(j) * 131072 + sides) / (2 * sides), 0, !(m_tangents || m_normals));
    end
    if (m_tangents) begin
      tx = 0;
      ty = 0;
      if (wide != 0) begin
        tx = rnd_shift(-st, 14);
        ty = rnd_shift(ct, 14);
        if (wide < 0) begin
          tx = -tx;
          ty = -ty;
        end
      end
      push_rec(REC_TANGENT, tx, ty, 0, !m_normals);
    end
    if (m_normals) begin
      push_rec(REC_NORMAL, rnd_shift(ct * cp, 44), rnd_shift(st * cp, 44), rnd_shift(sp, 14),
               1'b1);
    end
  endfunction

  // The driver holds a command while busy and otherwise works in bursts.
  always @(posedge clk) begin
    logic go;
    if (rst) begin
      start <= 1'b0;
      command <= 1'b0;
      ring_index <= '0;
      side_index <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_records(pending_cmds.pop_front());
      end
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        go = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      start <= go;
      if (go) begin
        command <= pending_cmds[0].cmd;
        ring_index <= pending_cmds[0].ri;
        side_index <= pending_cmds[0].si;
      end
    end
  end

  always @(posedge clk) begin
    mesh_rec_t e;
    if (!rst) begin
      if (valid) begin
        if (expected_recs.size() == 0) begin
          $error("record transfer with nothing expected: type %0d", record_type);
          error_count++;
        end else begin
          e = expected_recs.pop_front();
          if (record_type !== e.kind) begin
            $error("record_type expected %0d actual %0d", e.kind, record_type);
            error_count++;
          end
          if (value_a !== e.a) begin
            $error("value_a expected %0d actual %0d", e.a, value_a);
            error_count++;
          end
          if (value_b !== e.b) begin
            $error("value_b expected %0d actual %0d", e.b, value_b);
            error_count++;
          end
          if (value_c !== e.c) begin
            $error("value_c expected %0d actual %0d", e.c, value_c);
            error_count++;
          end
          if (last !== e.fin) begin
            $error("last expected %0d actual %0d", e.fin, last);
            error_count++;
          end
        end
      end
      if (valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("torus_mesh_generator test failed");
        $finish;
      end
    end
  end

  task automatic add_cmd(cmd_t cmd, int ri, int si);
    mesh_cmd_t m;
    m.cmd = cmd;
    m.ri = ri[IDX_W-1:0];
    m.si = si[IDX_W-1:0];
    pending_cmds.push_back(m);
  endtask

  task automatic add_random(int n);
    int rings, sides;
    rings = eff_count(m_rings);
    sides = eff_count(m_sides);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_cmd(cmd_t'($urandom_range(0, 1)), $urandom_range(0, 511), $urandom_range(0, 511));
      end else begin
        add_cmd(cmd_t'($urandom_range(0, 1)), $urandom_range(0, rings),
                $urandom_range(0, sides));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_recs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    case (idx)
      CFG_RING_COUNT: m_rings = data[COUNT_W-1:0];
      CFG_SIDE_COUNT: m_sides = data[COUNT_W-1:0];
      CFG_INNER_RADIUS: m_inner = data[RAD_W-1:0];
      CFG_OUTER_RADIUS: m_outer = data[RAD_W-1:0];
      CFG_CLOSED_MODE: m_closed = data[0];
      CFG_EMIT_NORMALS: m_normals = data[0];
      CFG_EMIT_TEXCOORDS: m_texcoords = data[0];
      default: m_tangents = data[0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(int unsigned rings, int unsigned sides, int unsigned inner,
                           int unsigned outer, bit closed, bit nrm, bit tex, bit tan);
    write_reg(CFG_RING_COUNT, rings);
    write_reg(CFG_SIDE_COUNT, sides);
    write_reg(CFG_INNER_RADIUS, inner);
    write_reg(CFG_OUTER_RADIUS, outer);
    write_reg(CFG_CLOSED_MODE, closed);
    write_reg(CFG_EMIT_NORMALS, nrm);
    write_reg(CFG_EMIT_TEXCOORDS, tex);
    write_reg(CFG_EMIT_TANGENTS, tan);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Grid corners, half turns, seam points and out-of-grid commands at reset settings.
    add_cmd(CMD_VERTEX, 0, 0);
    add_cmd(CMD_VERTEX, 10, 10);
    add_cmd(CMD_VERTEX, 11, 0);
    add_cmd(CMD_VERTEX, 0, 11);
    add_cmd(CMD_VERTEX, 511, 511);
    add_cmd(CMD_VERTEX, 256, 256);
    add_cmd(CMD_VERTEX, 5, 5);
    add_cmd(CMD_VERTEX, 3, 7);
    add_cmd(CMD_VERTEX, 2, 4);
    add_cmd(CMD_FACE, 0, 0);
    add_cmd(CMD_FACE, 9, 9);
    add_cmd(CMD_FACE, 10, 0);
    add_cmd(CMD_FACE, 0, 10);
    add_cmd(CMD_FACE, 511, 511);
    add_cmd(CMD_FACE, 4, 6);
    add_random(40);
    wait_idle();

    configure(0, 0, 131072, 0, 0, 1, 1, 1);
    add_cmd(CMD_VERTEX, 1, 1);
    add_cmd(CMD_FACE, 0, 0);
    add_random(30);
    wait_idle();

    configure(256, 256, 131072, 131072, 1, 1, 1, 1);
    add_cmd(CMD_VERTEX, 255, 255);
    add_cmd(CMD_VERTEX, 256, 0);
    add_cmd(CMD_FACE, 255, 255);
    add_random(40);
    wait_idle();

    configure(4, 4, 65536, 0, 0, 0, 1, 1);
    add_cmd(CMD_VERTEX, 1, 1);
    add_cmd(CMD_VERTEX, 1, 2);
    add_cmd(CMD_VERTEX, 3, 3);
    add_random(40);
    wait_idle();

    configure(511, 7, 131072, 65536, 1, 1, 0, 0);
    add_random(40);
    wait_idle();

    configure(3, 5, 0, 0, 0, 0, 0, 0);
    add_random(40);
    wait_idle();

    configure(13, 256, 0, 131072, 0, 1, 1, 1);
    add_random(40);
    wait_idle();

    configure(10, 10, 16384, 49152, 1, 1, 0, 1);
    add_random(40);
    wait_idle();

    if (error_count == 0) begin
      $display("torus_mesh_generator test passed");
    end else begin
      $display("torus_mesh_generator test failed");
    end
    $finish;
  end

endmodule
